@@ rtl/core/owner_filtered_note_keyword_matcher_assert.svh @@
// Assertion macros used by the matcher's checker
`ifndef OWNER_FILTERED_NOTE_KEYWORD_MATCHER_ASSERT_SVH
`define OWNER_FILTERED_NOTE_KEYWORD_MATCHER_ASSERT_SVH

// condition and consequence sampled at the same edge
`define ONKM_ASSERT_SAME(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequence checked at the edge after the condition
`define ONKM_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/onkm_pkg.sv @@
// Shared types and constants for the note keyword matcher
`timescale 1ns / 1ps
`default_nettype none

package onkm_pkg;

    localparam int unsigned MAX_KEYWORD  = 32;
    localparam int unsigned MAX_NOTE_LEN = 255;

    localparam int unsigned KW_LEN_W   = $clog2(MAX_KEYWORD + 1);
    localparam int unsigned KW_IDX_W   = $clog2(MAX_KEYWORD);
    localparam int unsigned CNT_W      = $clog2(MAX_NOTE_LEN + 1);
    localparam int unsigned NOTE_LEN_W = 8;
    localparam int unsigned OWNER_W    = 32;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned KW_WORDS   = 4;
    localparam int unsigned KW_BITS    = KW_WORDS * CFG_DATA_W;

    localparam int unsigned OUT_FIELDS_W = NOTE_LEN_W + 3;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [CFG_ADDR_W-1:0] REG_USER_ID        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KW_LEN         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEYWORD_WORD_0 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEYWORD_WORD_1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEYWORD_WORD_2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KEYWORD_WORD_3 = 3'd5;

    localparam logic [7:0] NEWLINE   = 8'h0A;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    typedef enum logic [2:0] {
        PH_ID0,
        PH_ID1,
        PH_ID2,
        PH_ID3,
        PH_SEP,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        OP_ID,
        OP_BODY,
        OP_EOF
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [OWNER_W-1:0]  user_id;
        logic [KW_LEN_W-1:0] kw_len;
        logic [KW_BITS-1:0]  keyword;
    } match_cfg_t;

    typedef struct packed {
        logic                  incomplete;
        logic                  length_overflow;
        logic [NOTE_LEN_W-1:0] body_len;
        logic                  keyword_found;
        logic                  owner_match;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/owner_filtered_note_keyword_matcher.sv @@
// A record's newline (or end of stream) passes through the queue after its acceptance
// and is then loaded into the result register that drives m_.
// Throughput: one byte per cycle; the front end stalls only when the four-entry queue fills,
// which happens only while a result waits on m_tready.
// Reset: synchronous, active low; clears framing, queue, match state, result valid and
// all configuration registers. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module owner_filtered_note_keyword_matcher (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  wire logic                              s_tlast,   // end_of_file
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] owner_match, [1] keyword_found, [9:2] body length, [10] length_overflow, rest zero
    output logic [onkm_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tuser,   // [0] incomplete
    input  wire logic                              cfg_wr_en,
    input  wire logic [onkm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [onkm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [onkm_pkg::OWNER_W-1:0]    user_id_reg;
    logic [onkm_pkg::KW_LEN_W-1:0]   kw_len_reg;
    logic [onkm_pkg::CFG_DATA_W-1:0] kw_word_reg [onkm_pkg::KW_WORDS];

    onkm_pkg::match_cfg_t cfg;
    onkm_pkg::cmd_t       push_item;
    onkm_pkg::cmd_t       q_item;
    onkm_pkg::result_t    result;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            user_id_reg    <= '0;
            kw_len_reg     <= '0;
            kw_word_reg[0] <= '0;
            kw_word_reg[1] <= '0;
            kw_word_reg[2] <= '0;
            kw_word_reg[3] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                onkm_pkg::REG_USER_ID:        user_id_reg <= cfg_wdata[onkm_pkg::OWNER_W-1:0];
                onkm_pkg::REG_KW_LEN:         kw_len_reg <= cfg_wdata[onkm_pkg::KW_LEN_W-1:0];
                onkm_pkg::REG_KEYWORD_WORD_0: kw_word_reg[0] <= cfg_wdata;
                onkm_pkg::REG_KEYWORD_WORD_1: kw_word_reg[1] <= cfg_wdata;
                onkm_pkg::REG_KEYWORD_WORD_2: kw_word_reg[2] <= cfg_wdata;
                onkm_pkg::REG_KEYWORD_WORD_3: kw_word_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.user_id = user_id_reg;
        cfg.kw_len  = kw_len_reg;
        cfg.keyword = {kw_word_reg[3], kw_word_reg[2], kw_word_reg[1], kw_word_reg[0]};
    end

    onkm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    onkm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    onkm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .result   (result)
    );

    assign m_tdata = {{(onkm_pkg::OUT_DATA_W - onkm_pkg::OUT_FIELDS_W){1'b0}},
                      result.length_overflow, result.body_len,
                      result.keyword_found, result.owner_match};
    assign m_tuser = result.incomplete;

endmodule

`default_nettype wire

@@ rtl/core/onkm_front.sv @@
// Front end: tracks record framing and classifies each incoming byte
`timescale 1ns / 1ps
`default_nettype none

module onkm_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    input  wire logic           s_tlast,
    input  wire logic           q_full,
    output logic                push,
    output onkm_pkg::cmd_t      push_item
);

    onkm_pkg::phase_t phase_reg, phase_next;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= onkm_pkg::PH_ID0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        push           = 1'b0;
        push_item.op   = onkm_pkg::OP_BODY;
        push_item.idx  = phase_reg[1:0];
        push_item.data = s_tdata;
        if (accept) begin
            if (s_tlast) begin
                // end of stream between records gives nothing
                if (phase_reg != onkm_pkg::PH_ID0) begin
                    push         = 1'b1;
                    push_item.op = onkm_pkg::OP_EOF;
                end
                phase_next = onkm_pkg::PH_ID0;
            end else begin
                case (phase_reg)
                    onkm_pkg::PH_ID0, onkm_pkg::PH_ID1,
                    onkm_pkg::PH_ID2, onkm_pkg::PH_ID3: begin
                        push         = 1'b1;
                        push_item.op = onkm_pkg::OP_ID;
                        phase_next   = onkm_pkg::phase_t'(phase_reg + 3'd1);
                    end
                    onkm_pkg::PH_SEP: begin
                        phase_next = onkm_pkg::PH_BODY;
                    end
                    onkm_pkg::PH_BODY: begin
                        push = 1'b1;
                        if (s_tdata == onkm_pkg::NEWLINE) begin
                            phase_next = onkm_pkg::PH_ID0;
                        end
                    end
                    default: begin
                        phase_next = onkm_pkg::PH_ID0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/onkm_fifo.sv @@
// Short command queue between the front end and the match engine
`timescale 1ns / 1ps
`default_nettype none

module onkm_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire onkm_pkg::cmd_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output onkm_pkg::cmd_t       q_item
);

    onkm_pkg::cmd_t                 mem [onkm_pkg::Q_DEPTH];
    logic [onkm_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [onkm_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [onkm_pkg::Q_PTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (onkm_pkg::Q_PTR_W + 1)'(onkm_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/onkm_back.sv @@
// Match engine: owner id, body count, keyword search, result register
`timescale 1ns / 1ps
`default_nettype none

module onkm_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire onkm_pkg::match_cfg_t cfg,
    input  wire logic                 q_valid,
    input  wire onkm_pkg::cmd_t       q_item,
    output logic                      pop,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output onkm_pkg::result_t         result
);

    logic [onkm_pkg::OWNER_W-1:0]  owner_reg, owner_next;
    logic [onkm_pkg::KW_LEN_W-1:0] match_reg, match_next;
    logic                          found_reg, found_next;
    logic                          zero_reg, zero_next;
    logic [onkm_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic                          out_valid_reg, out_valid_next;
    onkm_pkg::result_t             out_reg, out_next;

    logic [onkm_pkg::KW_LEN_W-1:0] klen;
    logic [onkm_pkg::KW_LEN_W-1:0] match_step;
    logic [7:0]                    kw_cur;
    logic                          zero_now;
    logic                          produces;
    logic                          out_free;
    logic                          res_load;
    logic                          clear;

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    assign klen = (cfg.kw_len > onkm_pkg::KW_LEN_W'(onkm_pkg::MAX_KEYWORD)) ?
                  onkm_pkg::KW_LEN_W'(onkm_pkg::MAX_KEYWORD) : cfg.kw_len;
    assign kw_cur = cfg.keyword[8 * match_reg[onkm_pkg::KW_IDX_W-1:0] +: 8];

    assign produces = (q_item.op == onkm_pkg::OP_EOF) ||
                      (q_item.op == onkm_pkg::OP_BODY && q_item.data == onkm_pkg::NEWLINE);
    assign out_free = !out_valid_reg || m_tready;
    // items that give no result never wait on the output side
    assign pop      = q_valid && (!produces || out_free);

    always_comb begin
        owner_next = owner_reg;
        match_next = match_reg;
        found_next = found_reg;
        zero_next  = zero_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        out_next   = out_reg;
        res_load   = 1'b0;
        clear      = 1'b0;
        zero_now   = zero_reg;
        match_step = match_reg;
        if (pop) begin
            case (q_item.op)
                onkm_pkg::OP_ID: begin
                    owner_next[8 * q_item.idx +: 8] = q_item.data;
                end
                onkm_pkg::OP_BODY: begin
                    if (count_reg >= onkm_pkg::CNT_W'(onkm_pkg::MAX_NOTE_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                    zero_now  = zero_reg || (q_item.data == onkm_pkg::ZERO_BYTE);
                    zero_next = zero_now;
                    if (!zero_now && !found_reg && klen != '0) begin
                        // restart at one on a first-byte hit, not a full failure table
                        if (match_reg < klen && q_item.data == kw_cur) begin
                            match_step = match_reg + 1'b1;
                        end else if (q_item.data == cfg.keyword[7:0]) begin
                            match_step = onkm_pkg::KW_LEN_W'(1);
                        end else begin
                            match_step = '0;
                        end
                        match_next = match_step;
                        if (match_step == klen) begin
                            found_next = 1'b1;
                        end
                    end
                    if (q_item.data == onkm_pkg::NEWLINE) begin
                        res_load                 = 1'b1;
                        clear                    = 1'b1;
                        out_next.owner_match     = (owner_reg == cfg.user_id);
                        out_next.keyword_found   = (owner_reg == cfg.user_id) &&
                                                   (klen == '0 || found_next);
                        out_next.body_len        = onkm_pkg::NOTE_LEN_W'(count_next);
                        out_next.length_overflow = ovf_next;
                        out_next.incomplete      = 1'b0;
                    end
                end
                onkm_pkg::OP_EOF: begin
                    res_load = 1'b1;
                    clear    = 1'b1;
                    out_next = '0;
                    out_next.incomplete = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (clear) begin
            owner_next = '0;
            match_next = '0;
            found_next = 1'b0;
            zero_next  = 1'b0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (res_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg     <= '0;
            match_reg     <= '0;
            found_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            owner_reg     <= owner_next;
            match_reg     <= match_next;
            found_reg     <= found_next;
            zero_reg      <= zero_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/onkm_checker.sv @@
// Port-level checker for the matcher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "owner_filtered_note_keyword_matcher_assert.svh"

module onkm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [onkm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire logic                              m_tuser
);

    // a result is never shown straight out of reset
    `ONKM_ASSERT_NEXT(a_reset_quiet, aclk, !aresetn, !m_tvalid)

    // an incomplete item carries nothing else
    `ONKM_ASSERT_SAME(a_incomplete_clean, aclk, aresetn && m_tvalid && m_tuser, m_tdata == '0)

    // keyword is only reported for owned records
    `ONKM_ASSERT_SAME(a_found_owned, aclk, aresetn && m_tvalid && m_tdata[1], m_tdata[0])

    // overflow means the length sits at its saturated value
    `ONKM_ASSERT_SAME(a_ovf_saturated, aclk, aresetn && m_tvalid && m_tdata[10], m_tdata[9:2] == onkm_pkg::NOTE_LEN_W'(onkm_pkg::MAX_NOTE_LEN))

    // stalled result holds
    `ONKM_ASSERT_NEXT(a_hold_stalled, aclk, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind owner_filtered_note_keyword_matcher onkm_checker u_onkm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/owner_filtered_note_keyword_matcher_test.sv @@
// Self-checking testbench for the owner-filtered note keyword matcher.
`timescale 1ns / 1ps

module owner_filtered_note_keyword_matcher_test;

    typedef logic [7:0] byte_q_t [$];

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 30;
    localparam int IDLE_PERCENT = 22;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            s_tlast   = 1'b0;
    logic                            m_tready  = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [onkm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [onkm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                             s_tready;
    wire                             m_tvalid;
    wire [onkm_pkg::OUT_DATA_W-1:0]  m_tdata;
    wire                             m_tuser;

    owner_filtered_note_keyword_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the configuration registers
    logic [31:0]  cfg_user = '0;
    logic [5:0]   cfg_klen = '0;
    logic [255:0] cfg_kw   = '0;

    // record scanner state
    onkm_pkg::phase_t rec_phase;
    logic [31:0]      owner_acc;
    int unsigned      match_cnt;
    int unsigned      body_cnt;
    bit               found_kw;
    bit               zero_hit;
    bit               len_over;

    onkm_pkg::result_t pending_results [$];
    int                mismatches      = 0;
    int                results_seen    = 0;
    int                incomplete_seen = 0;
    int                overflow_seen   = 0;
    int                items_sent      = 0;
    int                quiet_cycles    = 0;
    int                hold_left       = 0;
    bit                tx_idle_on      = 1'b1;
    bit                rx_idle_on      = 1'b1;

    always #5 aclk = ~aclk;

    function automatic logic [7:0] kw_at(int unsigned idx);
        return cfg_kw[(idx % onkm_pkg::MAX_KEYWORD) * 8 +: 8];
    endfunction

    function automatic void clear_record_state();
        rec_phase = onkm_pkg::PH_ID0;
        owner_acc = '0;
        match_cnt = 0;
        body_cnt  = 0;
        found_kw  = 1'b0;
        zero_hit  = 1'b0;
        len_over  = 1'b0;
    endfunction

    // Advances the record scanner by one accepted item and queues any result.
    function automatic void scan_note_byte(logic [7:0] b, bit eof);
        int unsigned       klen;
        onkm_pkg::result_t r;
        bit                owned;
        klen = (cfg_klen > onkm_pkg::MAX_KEYWORD) ? onkm_pkg::MAX_KEYWORD : cfg_klen;
        r = '0;
        if (eof) begin
            if (rec_phase != onkm_pkg::PH_ID0) begin
                r.incomplete = 1'b1;
                pending_results.push_back(r);
                clear_record_state();
            end
            return;
        end
        case (rec_phase)
            onkm_pkg::PH_ID0, onkm_pkg::PH_ID1, onkm_pkg::PH_ID2, onkm_pkg::PH_ID3: begin
                owner_acc[int'(rec_phase) * 8 +: 8] = b;
                rec_phase = onkm_pkg::phase_t'(rec_phase + 3'd1);
                return;
            end
            onkm_pkg::PH_SEP: begin
                rec_phase = onkm_pkg::PH_BODY;
                return;
            end
            default: ;
        endcase
        if (body_cnt >= onkm_pkg::MAX_NOTE_LEN)
            len_over = 1'b1;
        else
            body_cnt++;
        if (b == onkm_pkg::ZERO_BYTE)
            zero_hit = 1'b1;
        // restart rule: a mismatch falls back to 1 or 0, never to a longer border
        if (!zero_hit && !found_kw && klen > 0) begin
            if (match_cnt < klen && b == kw_at(match_cnt))
                match_cnt++;
            else if (b == kw_at(0))
                match_cnt = 1;
            else
                match_cnt = 0;
            if (match_cnt == klen)
                found_kw = 1'b1;
        end
        if (b == onkm_pkg::NEWLINE) begin
            owned             = (owner_acc == cfg_user);
            r.owner_match     = owned;
            r.keyword_found   = owned && (klen == 0 || found_kw);
            r.body_len        = body_cnt[7:0];
            r.length_overflow = len_over;
            pending_results.push_back(r);
            clear_record_state();
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        onkm_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.incomplete)
                    incomplete_seen++;
                if (want.length_overflow)
                    overflow_seen++;
                if (m_tdata[0] !== want.owner_match)
                    report_mismatch("owner_match", m_tdata[0], want.owner_match);
                if (m_tdata[1] !== want.keyword_found)
                    report_mismatch("keyword_found", m_tdata[1], want.keyword_found);
                if (m_tdata[9:2] !== want.body_len)
                    report_mismatch("body length", m_tdata[9:2], want.body_len);
                if (m_tdata[10] !== want.length_overflow)
                    report_mismatch("length_overflow", m_tdata[10], want.length_overflow);
                if (m_tdata[onkm_pkg::OUT_DATA_W-1:11] !== '0)
                    report_mismatch("tdata padding", m_tdata[onkm_pkg::OUT_DATA_W-1:11], 0);
                if (m_tuser !== want.incomplete)
                    report_mismatch("incomplete", m_tuser, want.incomplete);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("owner_filtered_note_keyword_matcher_test: FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    initial forever begin
        @(negedge aclk);
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [7:0] b, input bit eof);
        if (tx_idle_on) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        do @(posedge aclk); while (!s_tready);
        scan_note_byte(b, eof);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_bytes(input byte_q_t stream);
        foreach (stream[i])
            send_item(stream[i], 1'b0);
    endtask

    task automatic send_record(input logic [31:0] owner, input logic [7:0] sep,
                               input byte_q_t body);
        byte_q_t stream;
        stream = {owner[7:0], owner[15:8], owner[23:16], owner[31:24], sep};
        stream = {stream, body};
        send_bytes(stream);
    endtask

    // wait for the block to drain before touching configuration
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [onkm_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        case (addr)
            onkm_pkg::REG_USER_ID:        cfg_user = value[31:0];
            onkm_pkg::REG_KW_LEN:         cfg_klen = value[5:0];
            onkm_pkg::REG_KEYWORD_WORD_0: cfg_kw[63:0]    = value;
            onkm_pkg::REG_KEYWORD_WORD_1: cfg_kw[127:64]  = value;
            onkm_pkg::REG_KEYWORD_WORD_2: cfg_kw[191:128] = value;
            onkm_pkg::REG_KEYWORD_WORD_3: cfg_kw[255:192] = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [31:0] user, input logic [5:0] klen,
                               input logic [255:0] kw);
        settle();
        write_reg(onkm_pkg::REG_USER_ID, {32'h0, user});
        write_reg(onkm_pkg::REG_KW_LEN, {58'h0, klen});
        write_reg(onkm_pkg::REG_KEYWORD_WORD_0, kw[63:0]);
        write_reg(onkm_pkg::REG_KEYWORD_WORD_1, kw[127:64]);
        write_reg(onkm_pkg::REG_KEYWORD_WORD_2, kw[191:128]);
        write_reg(onkm_pkg::REG_KEYWORD_WORD_3, kw[255:192]);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == onkm_pkg::NEWLINE || b == onkm_pkg::ZERO_BYTE);
        return b;
    endfunction

    // mostly a small alphabet so that keyword hits and near misses are common
    function automatic logic [255:0] make_keyword(int zero_pct);
        logic [255:0] kw;
        int           r;
        for (int i = 0; i < 32; i++) begin
            r = $urandom_range(99);
            if (r < zero_pct)
                kw[i*8 +: 8] = onkm_pkg::ZERO_BYTE;
            else if (r < 80)
                kw[i*8 +: 8] = 8'h61 + 8'($urandom_range(3));
            else
                kw[i*8 +: 8] = any_text_byte();
        end
        return kw;
    endfunction

    // One record with random content of the given total body length (newline included).
    task automatic send_random_record(input int unsigned total_len, input bit noisy);
        byte_q_t     body;
        byte_q_t     stream;
        logic [31:0] owner;
        int unsigned klen;
        int unsigned take;
        int          r;
        int          cut;
        klen = (cfg_klen > onkm_pkg::MAX_KEYWORD) ? onkm_pkg::MAX_KEYWORD : cfg_klen;
        r = $urandom_range(99);
        if (r < 70)
            owner = cfg_user;
        else if (r < 85)
            owner = cfg_user ^ (32'h1 << $urandom_range(31));
        else
            owner = $urandom;
        while (body.size() < total_len - 1) begin
            r = $urandom_range(99);
            if (r < 35 && klen > 0) begin
                take = ($urandom_range(99) < 70) ? klen : $urandom_range(1, klen);
                for (int i = 0; i < take && body.size() < total_len - 1; i++)
                    body.push_back(kw_at(i));
            end else if (r < 45) begin
                body.push_back(kw_at(0));
            end else if (r < 85) begin
                body.push_back(8'h61 + 8'($urandom_range(3)));
            end else if (r < 95) begin
                body.push_back(any_text_byte());
            end else begin
                body.push_back(onkm_pkg::ZERO_BYTE);
            end
        end
        body.push_back(onkm_pkg::NEWLINE);
        stream = {owner[7:0], owner[15:8], owner[23:16], owner[31:24],
                  8'($urandom_range(255))};
        stream = {stream, body};
        r = $urandom_range(99);
        if (noisy && r < 8) begin
            // stream ends inside the record
            cut = $urandom_range(1, stream.size() - 1);
            for (int i = 0; i < cut; i++)
                send_item(stream[i], 1'b0);
            send_item(8'($urandom_range(255)), 1'b1);
        end else begin
            send_bytes(stream);
            if (noisy && r < 12) begin
                send_item(8'($urandom_range(255)), 1'b1);
            end else if (noisy && r < 15) begin
                // stray bytes that knock the framing out of step
                repeat ($urandom_range(1, 6))
                    send_item(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    function automatic int unsigned short_length();
        return ($urandom_range(9) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 17);
    endfunction

    task automatic test_reset_defaults();
        byte_q_t body;
        // empty keyword after reset: owner zero always matches
        body = {onkm_pkg::NEWLINE};
        send_record(32'h0000_0000, 8'hFF, body);
        // end of stream between records gives nothing
        send_item(8'hA5, 1'b1);
    endtask

    task automatic test_keyword_rules();
        byte_q_t body;
        load_config(32'hFFFF_FFFF, 6'd3, {216'h0, onkm_pkg::NEWLINE, 8'h62, 8'h61});
        // "aab\n": restart after the second 'a', newline completes the keyword
        body = {8'h61, 8'h61, 8'h62, onkm_pkg::NEWLINE};
        send_record(32'hFFFF_FFFF, onkm_pkg::NEWLINE, body);
        // zero byte stops the search but is still counted
        body = {onkm_pkg::ZERO_BYTE, 8'h61, 8'h62, onkm_pkg::NEWLINE};
        send_record(32'hFFFF_FFFF, onkm_pkg::ZERO_BYTE, body);
        // end of stream part-way through the owner id
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_output_backpressure();
        load_config($urandom, 6'd2, make_keyword(0));
        hold_left = HOLD_CYCLES;
        repeat (30)
            send_random_record($urandom_range(1, 4), 1'b0);
    endtask

    task automatic test_random_stream();
        logic [31:0]  user;
        logic [5:0]   klen;
        logic [255:0] kw;
        int           start;
        int           long_items;
        int           rec;
        for (int phase = 0; phase < 7; phase++) begin
            user = $urandom;
            kw   = make_keyword(0);
            case (phase)
                0: klen = 6'($urandom_range(2, 6));
                1: begin
                    user = 32'h0000_0000;
                    klen = 6'd0;
                    kw   = '1;
                end
                2: begin
                    user = 32'hFFFF_FFFF;
                    klen = 6'd32;
                end
                3: begin
                    klen = 6'($urandom_range(33, 63));
                    kw   = make_keyword(3);
                end
                4: klen = 6'd1;
                5: begin
                    klen = 6'($urandom_range(2, 8));
                    kw   = make_keyword(20);
                end
                default: begin
                    klen = 6'd4;
                    kw   = '0;
                end
            endcase
            load_config(user, klen, kw);
            // one phase runs with no stalls on either side
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);
            start      = items_sent;
            long_items = 0;
            rec        = 0;
            while (items_sent - start - long_items < PHASE_ITEMS) begin
                if (phase == 0 && rec == 0) begin
                    send_random_record(onkm_pkg::MAX_NOTE_LEN, 1'b0);
                    long_items += onkm_pkg::MAX_NOTE_LEN + 5;
                end else if (phase == 2 && rec == 0) begin
                    send_random_record(onkm_pkg::MAX_NOTE_LEN + 1, 1'b0);
                    long_items += onkm_pkg::MAX_NOTE_LEN + 6;
                end else begin
                    send_random_record(short_length(), 1'b1);
                end
                rec++;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        clear_record_state();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_keyword_rules();
        test_output_backpressure();
        test_random_stream();
        settle();
        $display("%0d items sent, %0d results checked: %0d cut short, %0d length overflow",
                 items_sent, results_seen, incomplete_seen, overflow_seen);
        $display("keywords: empty, single byte, full width, over-long, zero bytes; output held off for %0d cycles",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("owner_filtered_note_keyword_matcher_test: PASS");
        else
            $display("owner_filtered_note_keyword_matcher_test: FAIL");
        $finish;
    end

endmodule
